// ----- sv/m2x2_pkg.sv -----
// shared types and constants for the 2x2 matrix arithmetic unit
package m2x2_pkg;

   localparam int Q_WIDTH = 32;
   localparam int LANES   = 4;

   // command codes
   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_NEG  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_MVEC = 3'd4;
   localparam logic [2:0] CMD_INV  = 3'd5;

   localparam logic signed [Q_WIDTH-1:0] Q_MAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
   localparam logic signed [Q_WIDTH-1:0] Q_MIN = {1'b1, {(Q_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [2:0]                command;
      logic signed [Q_WIDTH-1:0] a00;
      logic signed [Q_WIDTH-1:0] a01;
      logic signed [Q_WIDTH-1:0] a10;
      logic signed [Q_WIDTH-1:0] a11;
      logic signed [Q_WIDTH-1:0] b00;
      logic signed [Q_WIDTH-1:0] b01;
      logic signed [Q_WIDTH-1:0] b10;
      logic signed [Q_WIDTH-1:0] b11;
   } req_type;

   typedef struct packed {
      logic signed [Q_WIDTH-1:0] r00;
      logic signed [Q_WIDTH-1:0] r01;
      logic signed [Q_WIDTH-1:0] r10;
      logic signed [Q_WIDTH-1:0] r11;
      logic                      singular;
      logic                      saturated;
   } rsp_type;

   // one lane of the restoring divider
   typedef struct packed {
      logic [63:0]        rem;
      logic [Q_WIDTH-1:0] lo;
      logic [Q_WIDTH-1:0] quo;
      logic               ovf;
      logic               neg;
   } div_lane_type;

   // one stage of the divider pipeline, with the non-inverse result riding along
   typedef struct packed {
      logic                          valid;
      logic                          is_inv;
      logic                          singular;
      logic [63:0]                   ud;
      div_lane_type [LANES-1:0]      lane;
      rsp_type                       side;
   } div_stage_type;

endpackage

// ----- sv/m2x2_front.sv -----
// front stages: products, sums, rounding, determinant magnitude and divider setup
module m2x2_front
   import m2x2_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  req_type       in_req,
   input  logic [31:0]   threshold,
   output div_stage_type out_stage
);

   localparam int NUM_W = Q_WIDTH + 2 * FRAC_BITS;
   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   // stage a: input register
   logic    s1_valid_ff;
   req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_req_ff <= in_req;
   end

   // stage b: all products and the element-wise operations
   logic                      s2_valid_ff;
   req_type                   s2_req_ff;
   logic signed [63:0]        prod_in [10];
   logic signed [63:0]        prod_ff [10];
   logic signed [Q_WIDTH:0]   lin_in  [LANES];
   logic signed [Q_WIDTH:0]   lin_ff  [LANES];

   always_comb begin
      prod_in[0] = s1_req_ff.a00 * s1_req_ff.b00;
      prod_in[1] = s1_req_ff.a01 * s1_req_ff.b10;
      prod_in[2] = s1_req_ff.a10 * s1_req_ff.b00;
      prod_in[3] = s1_req_ff.a11 * s1_req_ff.b10;
      prod_in[4] = s1_req_ff.a00 * s1_req_ff.b01;
      prod_in[5] = s1_req_ff.a01 * s1_req_ff.b11;
      prod_in[6] = s1_req_ff.a10 * s1_req_ff.b01;
      prod_in[7] = s1_req_ff.a11 * s1_req_ff.b11;
      prod_in[8] = s1_req_ff.a00 * s1_req_ff.a11;
      prod_in[9] = s1_req_ff.a10 * s1_req_ff.a01;
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lin_in[k] = '0;
      end
      unique case (s1_req_ff.command)
         CMD_ADD: begin
            lin_in[0] = 33'(s1_req_ff.a00) + 33'(s1_req_ff.b00);
            lin_in[1] = 33'(s1_req_ff.a01) + 33'(s1_req_ff.b01);
            lin_in[2] = 33'(s1_req_ff.a10) + 33'(s1_req_ff.b10);
            lin_in[3] = 33'(s1_req_ff.a11) + 33'(s1_req_ff.b11);
         end
         CMD_SUB: begin
            lin_in[0] = 33'(s1_req_ff.a00) - 33'(s1_req_ff.b00);
            lin_in[1] = 33'(s1_req_ff.a01) - 33'(s1_req_ff.b01);
            lin_in[2] = 33'(s1_req_ff.a10) - 33'(s1_req_ff.b10);
            lin_in[3] = 33'(s1_req_ff.a11) - 33'(s1_req_ff.b11);
         end
         CMD_NEG: begin
            lin_in[0] = -33'(s1_req_ff.a00);
            lin_in[1] = -33'(s1_req_ff.a01);
            lin_in[2] = -33'(s1_req_ff.a10);
            lin_in[3] = -33'(s1_req_ff.a11);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_req_ff <= s1_req_ff;
      prod_ff   <= prod_in;
      lin_ff    <= lin_in;
   end

   // stage c: dot sums, determinant, clamp of element-wise results
   logic                      s3_valid_ff;
   req_type                   s3_req_ff;
   logic signed [65:0]        dot_in    [LANES];
   logic signed [65:0]        dot_ff    [LANES];
   logic signed [64:0]        det_in;
   logic signed [64:0]        det_ff;
   logic signed [Q_WIDTH-1:0] linc_in   [LANES];
   logic signed [Q_WIDTH-1:0] linc_ff   [LANES];
   logic                      linsat_in [LANES];
   logic                      linsat_ff [LANES];

   always_comb begin
      dot_in[0] = 66'(prod_ff[0]) + 66'(prod_ff[1]);
      dot_in[1] = 66'(prod_ff[4]) + 66'(prod_ff[5]);
      dot_in[2] = 66'(prod_ff[2]) + 66'(prod_ff[3]);
      dot_in[3] = 66'(prod_ff[6]) + 66'(prod_ff[7]);
      det_in    = 65'(prod_ff[8]) - 65'(prod_ff[9]);
      for (int k = 0; k < LANES; k++) begin
         linsat_in[k] = lin_ff[k][Q_WIDTH] != lin_ff[k][Q_WIDTH-1];
         if (linsat_in[k]) begin
            linc_in[k] = lin_ff[k][Q_WIDTH] ? Q_MIN : Q_MAX;
         end else begin
            linc_in[k] = lin_ff[k][Q_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_req_ff <= s2_req_ff;
      dot_ff    <= dot_in;
      det_ff    <= det_in;
      linc_ff   <= linc_in;
      linsat_ff <= linsat_in;
   end

   // stage d: round the products, determinant magnitude, element magnitudes
   logic                      s4_valid_ff;
   logic [2:0]                s4_cmd_ff;
   logic signed [65:0]        rnd    [LANES];
   logic                      dsat   [LANES];
   logic signed [Q_WIDTH-1:0] dval   [LANES];
   logic signed [Q_WIDTH-1:0] src    [LANES];
   logic                      dneg;
   logic [63:0]               ud_in;
   logic [63:0]               ud_ff;
   logic [Q_WIDTH-1:0]        ux_in  [LANES];
   logic [Q_WIDTH-1:0]        ux_ff  [LANES];
   logic                      neg_in [LANES];
   logic                      neg_ff [LANES];
   rsp_type                   side_in;
   rsp_type                   side_ff;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rnd[k]  = (dot_ff[k] + HALF) >>> FRAC_BITS;
         dsat[k] = !((&rnd[k][65:Q_WIDTH-1]) || !(|rnd[k][65:Q_WIDTH-1]));
         if (dsat[k]) begin
            dval[k] = rnd[k][65] ? Q_MIN : Q_MAX;
         end else begin
            dval[k] = rnd[k][Q_WIDTH-1:0];
         end
      end
   end

   // lane order follows r00, r01, r10, r11 of the inverse
   always_comb begin
      dneg   = det_ff[64];
      ud_in  = dneg ? 64'(-det_ff) : 64'(det_ff);
      src[0] = s3_req_ff.a11;
      src[1] = s3_req_ff.a01;
      src[2] = s3_req_ff.a10;
      src[3] = s3_req_ff.a00;
      for (int k = 0; k < LANES; k++) begin
         ux_in[k] = src[k][Q_WIDTH-1] ? Q_WIDTH'(-src[k]) : Q_WIDTH'(src[k]);
      end
      neg_in[0] = src[0][Q_WIDTH-1] ^ dneg;
      neg_in[1] = !src[1][Q_WIDTH-1] ^ dneg;
      neg_in[2] = !src[2][Q_WIDTH-1] ^ dneg;
      neg_in[3] = src[3][Q_WIDTH-1] ^ dneg;
   end

   // result of every command but the inverse
   always_comb begin
      side_in = '0;
      unique case (s3_req_ff.command)
         CMD_ADD, CMD_SUB, CMD_NEG: begin
            side_in.r00       = linc_ff[0];
            side_in.r01       = linc_ff[1];
            side_in.r10       = linc_ff[2];
            side_in.r11       = linc_ff[3];
            side_in.saturated = linsat_ff[0] | linsat_ff[1] | linsat_ff[2] | linsat_ff[3];
         end
         CMD_MUL: begin
            side_in.r00       = dval[0];
            side_in.r01       = dval[1];
            side_in.r10       = dval[2];
            side_in.r11       = dval[3];
            side_in.saturated = dsat[0] | dsat[1] | dsat[2] | dsat[3];
         end
         CMD_MVEC: begin
            side_in.r00       = dval[0];
            side_in.r10       = dval[2];
            side_in.saturated = dsat[0] | dsat[2];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_cmd_ff <= s3_req_ff.command;
      ud_ff     <= ud_in;
      ux_ff     <= ux_in;
      neg_ff    <= neg_in;
      side_ff   <= side_in;
   end

   // stage e: singular test, overflow test and divider start values
   logic [NUM_W-1:0] numer [LANES];
   logic [63:0]      hi    [LANES];
   div_stage_type    out_in;
   div_stage_type    out_ff;

   always_comb begin
      out_in          = '0;
      out_in.valid    = s4_valid_ff;
      out_in.is_inv   = s4_cmd_ff == CMD_INV;
      out_in.singular = (ud_ff == 64'd0) || (ud_ff < 64'(threshold));
      out_in.ud       = ud_ff;
      out_in.side     = side_ff;
      for (int k = 0; k < LANES; k++) begin
         numer[k]             = {ux_ff[k], {(2 * FRAC_BITS){1'b0}}};
         hi[k]                = 64'(numer[k][NUM_W-1:Q_WIDTH]);
         out_in.lane[k].ovf   = hi[k] >= ud_ff;
         out_in.lane[k].rem   = hi[k];
         out_in.lane[k].lo    = numer[k][Q_WIDTH-1:0];
         out_in.lane[k].quo   = '0;
         out_in.lane[k].neg   = neg_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign out_stage = out_ff;

endmodule

// ----- sv/m2x2_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage in each of four lanes
module m2x2_div_pipe
   import m2x2_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type din,
   output div_stage_type dout
);

   div_stage_type stage_ff [Q_WIDTH];

   for (genvar i = 0; i < Q_WIDTH; i++) begin : g_step
      div_stage_type cur;
      div_stage_type nxt;
      logic [64:0]   trial [LANES];
      logic          fits  [LANES];

      if (i == 0) begin : g_first
         assign cur = din;
      end else begin : g_next
         assign cur = stage_ff[i-1];
      end

      // shift in the next numerator bit and subtract when the divisor fits
      always_comb begin
         nxt = cur;
         for (int k = 0; k < LANES; k++) begin
            trial[k] = {cur.lane[k].rem, cur.lane[k].lo[Q_WIDTH-1]};
            fits[k]  = trial[k] >= {1'b0, cur.ud};
            if (fits[k]) begin
               trial[k] = trial[k] - {1'b0, cur.ud};
            end
            nxt.lane[k].rem = trial[k][63:0];
            nxt.lane[k].lo  = {cur.lane[k].lo[Q_WIDTH-2:0], 1'b0};
            nxt.lane[k].quo = {cur.lane[k].quo[Q_WIDTH-2:0], fits[k]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[i].valid <= 1'b0;
         end else begin
            stage_ff[i] <= nxt;
         end
      end
   end

   assign dout = stage_ff[Q_WIDTH-1];

endmodule

// ----- sv/m2x2_back.sv -----
// back stages: quotient rounding, clamp and sign, result selection and output register
module m2x2_back
   import m2x2_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type din,
   output logic          out_valid,
   output rsp_type       out_rsp
);

   localparam logic [Q_WIDTH:0] NEG_LIM = (Q_WIDTH+1)'(1) << (Q_WIDTH - 1);
   localparam logic [Q_WIDTH:0] POS_LIM = NEG_LIM - (Q_WIDTH+1)'(1);

   // round half up on the magnitude
   logic             m_valid_ff;
   logic             m_inv_ff;
   logic             m_sing_ff;
   rsp_type          m_side_ff;
   logic [Q_WIDTH:0] mag_in [LANES];
   logic [Q_WIDTH:0] mag_ff [LANES];
   logic             ovf_ff [LANES];
   logic             neg_ff [LANES];
   logic             up     [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         up[k]     = {din.lane[k].rem, 1'b0} >= {1'b0, din.ud};
         mag_in[k] = {1'b0, din.lane[k].quo} + (Q_WIDTH+1)'(up[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= din.valid;
      end
      m_inv_ff  <= din.is_inv;
      m_sing_ff <= din.singular;
      m_side_ff <= din.side;
      mag_ff    <= mag_in;
      for (int k = 0; k < LANES; k++) begin
         ovf_ff[k] <= din.lane[k].ovf;
         neg_ff[k] <= din.lane[k].neg;
      end
   end

   // clamp, apply sign and pick the result
   logic signed [Q_WIDTH-1:0] elem [LANES];
   logic                      esat [LANES];
   rsp_type                   rsp_in;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (neg_ff[k]) begin
            esat[k] = ovf_ff[k] || (mag_ff[k] > NEG_LIM);
            elem[k] = esat[k] ? Q_MIN : Q_WIDTH'(-mag_ff[k]);
         end else begin
            esat[k] = ovf_ff[k] || (mag_ff[k] > POS_LIM);
            elem[k] = esat[k] ? Q_MAX : Q_WIDTH'(mag_ff[k]);
         end
      end
      priority if (!m_inv_ff) begin
         rsp_in = m_side_ff;
      end else if (m_sing_ff) begin
         rsp_in          = '0;
         rsp_in.singular = 1'b1;
      end else begin
         rsp_in.r00       = elem[0];
         rsp_in.r01       = elem[1];
         rsp_in.r10       = elem[2];
         rsp_in.r11       = elem[3];
         rsp_in.singular  = 1'b0;
         rsp_in.saturated = esat[0] | esat[1] | esat[2] | esat[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- sv/matrix2x2_arith_unit.sv -----
// 2x2 matrix arithmetic unit: add, subtract, negate, product, matrix-vector, inverse
//
// The unit is a fixed-latency pipeline that takes one command in every clock
// cycle: busy is always low. Each result is strobed on rsp_valid for one cycle,
// in command order, whatever the command. The latency is set by the inverse
// path: five front stages (products, sums, rounding, determinant magnitude,
// divider setup), a 32-stage restoring divider that forms one quotient bit per
// stage in four lanes, and two stages for rounding, clamping and the output
// register. The receiver cannot stall, so every strobe must be taken. The
// singular threshold is written through the csr channel, which is always ready.
module matrix2x2_arith_unit
   import m2x2_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int PIPE_DEPTH = 5 + Q_WIDTH + 2;

   // threshold register
   logic [31:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // pipeline
   div_stage_type front_out;
   div_stage_type div_out;

   m2x2_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .threshold (threshold_ff),
      .out_stage (front_out)
   );

   m2x2_div_pipe u_div (
      .clock (clock),
      .reset (reset),
      .din   (front_out),
      .dout  (div_out)
   );

   m2x2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .din       (div_out),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

`ifndef SYNTHESIS
   // every result belongs to a transaction accepted a fixed time earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_DEPTH))
      else $error("result without a matching transaction");

   // a singular result is all zero and not saturated
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.r00 == '0 && rsp_data.r01 == '0 && rsp_data.r10 == '0 &&
          rsp_data.r11 == '0 && !rsp_data.saturated))
      else $error("singular result carries data");

   // only the inverse can report singular
   a_sing_inv_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.command != CMD_INV, PIPE_DEPTH)) |->
         !rsp_data.singular)
      else $error("singular flag on a command other than inverse");
`endif

endmodule

// ----- tb/matrix2x2_checker.sv -----
// checker for the 2x2 matrix unit: predicts every result and compares it field by field
module matrix2x2_checker
   import m2x2_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [67:0] wide_type;

   logic [31:0] det_limit;
   rsp_type     expected_results[$];

   // clamp to the 32-bit range, flagging saturation
   function automatic logic signed [31:0] clamp_q(wide_type v, inout bit sat);
      if (v > wide_type'(Q_MAX)) begin
         sat = 1;
         return Q_MAX;
      end
      if (v < wide_type'(Q_MIN)) begin
         sat = 1;
         return Q_MIN;
      end
      return v[31:0];
   endfunction

   // p*q + r*s, rounded half up to the fraction width, clamped
   function automatic logic signed [31:0] dot_pair(logic signed [31:0] p,
         logic signed [31:0] q, logic signed [31:0] r, logic signed [31:0] s,
         inout bit sat);
      wide_type wp, wq, wr, ws, acc;
      wp = p;
      wq = q;
      wr = r;
      ws = s;
      acc = wp * wq + wr * ws;
      acc = (acc + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return clamp_q(acc, sat);
   endfunction

   // signed |x| * 2^(2F) / ud, rounded to nearest with ties away from zero
   function automatic logic signed [31:0] inv_element(logic signed [31:0] x, bit neg,
         logic [63:0] ud, inout bit sat);
      logic [127:0] num, quo, rem, den;
      logic [63:0]  ux;
      ux = x[31] ? 64'(-longint'(x)) : 64'(longint'(x));
      if (ux == 0) return '0;
      den = {64'd0, ud};
      num = {64'd0, ux} << (2 * FRAC_BITS);
      quo = num / den;
      rem = num % den;
      if (rem >= den - rem) quo = quo + 1;
      if (neg) begin
         if (quo > 128'h8000_0000) begin
            sat = 1;
            return Q_MIN;
         end
         return -quo[31:0];
      end
      if (quo > 128'h7FFF_FFFF) begin
         sat = 1;
         return Q_MAX;
      end
      return quo[31:0];
   endfunction

   function automatic rsp_type predict_matrix_result(req_type t, logic [31:0] limit);
      rsp_type  r;
      bit       sat;
      wide_type wa00, wa01, wa10, wa11, det;
      logic [63:0] ud;
      bit       dneg;
      r = '0;
      sat = 0;
      wa00 = t.a00;
      wa01 = t.a01;
      wa10 = t.a10;
      wa11 = t.a11;
      case (t.command)
         CMD_ADD: begin
            r.r00 = clamp_q(wa00 + wide_type'(t.b00), sat);
            r.r01 = clamp_q(wa01 + wide_type'(t.b01), sat);
            r.r10 = clamp_q(wa10 + wide_type'(t.b10), sat);
            r.r11 = clamp_q(wa11 + wide_type'(t.b11), sat);
         end
         CMD_SUB: begin
            r.r00 = clamp_q(wa00 - wide_type'(t.b00), sat);
            r.r01 = clamp_q(wa01 - wide_type'(t.b01), sat);
            r.r10 = clamp_q(wa10 - wide_type'(t.b10), sat);
            r.r11 = clamp_q(wa11 - wide_type'(t.b11), sat);
         end
         CMD_NEG: begin
            r.r00 = clamp_q(-wa00, sat);
            r.r01 = clamp_q(-wa01, sat);
            r.r10 = clamp_q(-wa10, sat);
            r.r11 = clamp_q(-wa11, sat);
         end
         CMD_MUL: begin
            r.r00 = dot_pair(t.a00, t.b00, t.a01, t.b10, sat);
            r.r10 = dot_pair(t.a10, t.b00, t.a11, t.b10, sat);
            r.r01 = dot_pair(t.a00, t.b01, t.a01, t.b11, sat);
            r.r11 = dot_pair(t.a10, t.b01, t.a11, t.b11, sat);
         end
         CMD_MVEC: begin
            r.r00 = dot_pair(t.a00, t.b00, t.a01, t.b10, sat);
            r.r10 = dot_pair(t.a10, t.b00, t.a11, t.b10, sat);
         end
         CMD_INV: begin
            det  = wa00 * wa11 - wa10 * wa01;
            dneg = det < 0;
            ud   = dneg ? 64'(-det) : 64'(det);
            if (ud == 0 || ud < {32'd0, limit}) begin
               r.singular = 1;
            end else begin
               r.r00 = inv_element(t.a11, (t.a11 < 0) != dneg, ud, sat);
               r.r11 = inv_element(t.a00, (t.a00 < 0) != dneg, ud, sat);
               r.r01 = inv_element(t.a01, (t.a01 >= 0) != dneg, ud, sat);
               r.r10 = inv_element(t.a10, (t.a10 >= 0) != dneg, ud, sat);
            end
         end
         default: ;
      endcase
      r.saturated = sat;
      return r;
   endfunction

   assign pending = expected_results.size();

   // watch both channels and the csr port at every edge
   always_ff @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         det_limit <= 32'd1;
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) det_limit <= csr_data;
         if (start && !busy) expected_results.push_back(predict_matrix_result(req_data, det_limit));
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transaction %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.r00 !== rsp_data.r00 || want.r01 !== rsp_data.r01 ||
                   want.r10 !== rsp_data.r10 || want.r11 !== rsp_data.r11 ||
                   want.singular !== rsp_data.singular ||
                   want.saturated !== rsp_data.saturated) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected %h got %h", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/testbench.sv -----
// top of the 2x2 matrix unit testbench: clock, reset, stimulus and verdict
module testbench;
   import m2x2_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 40;
   localparam int STALL_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;
   int          fail_count;
   int          pending;
   int          idle_cycles;

   matrix2x2_arith_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   matrix2x2_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data), .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // random element: full range, near unity, or an extreme
   function automatic logic signed [31:0] pick_element();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 4) return $urandom;
      if (mode < 9) return $signed($urandom_range(0, 262143)) - 131072;
      case ($urandom_range(0, 5))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'sd0;
         3: return 32'sd1;
         4: return -32'sd1;
         default: return 32'sh0001_0000;
      endcase
   endfunction

   function automatic req_type random_command();
      req_type t;
      t.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
      t.a00 = pick_element();
      t.a01 = pick_element();
      t.a10 = pick_element();
      t.a11 = pick_element();
      t.b00 = pick_element();
      t.b01 = pick_element();
      t.b10 = pick_element();
      t.b11 = pick_element();
      return t;
   endfunction

   function automatic req_type make_command(logic [2:0] cmd, logic signed [31:0] a00,
         logic signed [31:0] a01, logic signed [31:0] a10, logic signed [31:0] a11,
         logic signed [31:0] b);
      req_type t;
      t.command = cmd;
      t.a00 = a00;
      t.a01 = a01;
      t.a10 = a10;
      t.a11 = a11;
      t.b00 = b;
      t.b01 = -b;
      t.b10 = b;
      t.b11 = ~b;
      return t;
   endfunction

   // one command transaction after a random gap
   task automatic send_command(req_type t);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1;
      req_data <= t;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] v);
      drain();
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   initial begin
      logic [31:0] limits[5];
      reset       = 1;
      start       = 0;
      req_data    = '0;
      csr_valid   = 0;
      csr_data    = '0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: extremes, every command, singular and saturating cases
      send_command(make_command(CMD_ADD, Q_MAX, Q_MIN, 1, -1, Q_MAX));
      send_command(make_command(CMD_ADD, Q_MIN, Q_MIN, 0, 5, Q_MIN));
      send_command(make_command(CMD_SUB, Q_MIN, Q_MAX, 7, 0, Q_MAX));
      send_command(make_command(CMD_SUB, 3, -3, 0, 0, 32'sh0001_0000));
      send_command(make_command(CMD_NEG, Q_MIN, Q_MAX, 0, -1, 0));
      send_command(make_command(CMD_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_command(make_command(CMD_MUL, Q_MAX, Q_MIN, 32'sh8000, 1, Q_MAX));
      send_command(make_command(CMD_MUL, 32'sh0001_8000, 32'sh0000_8000, -2, 1, 32'sh8000));
      send_command(make_command(CMD_MVEC, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
      send_command(make_command(CMD_MVEC, 32'sh0002_0000, 1, -1, 32'sh0001_0000, 32'sh1234));
      send_command(make_command(CMD_INV, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 0));
      send_command(make_command(CMD_INV, 32'sh0002_0000, 32'sh0001_0000,
                                32'sh0004_0000, 32'sh0002_0000, 0));
      send_command(make_command(CMD_INV, 1, 0, 0, 1, 0));
      send_command(make_command(CMD_INV, 1, 0, 0, 0, 0));
      send_command(make_command(CMD_INV, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 0));
      send_command(make_command(CMD_INV, Q_MIN, 0, 0, Q_MIN, 0));
      send_command(make_command(CMD_INV, 3, 1, -1, 3, 0));
      send_command(make_command(CMD_INV, -32'sh0003_0000, 32'sh0001_0000,
                                32'sh0002_0000, 32'sh0005_0000, 0));
      send_command(make_command(3'd6, Q_MAX, Q_MIN, 1, 1, Q_MAX));
      send_command(make_command(3'd7, Q_MIN, Q_MAX, -1, 1, Q_MIN));

      // threshold extremes, a random value and fixed values, each with a random batch
      limits = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'h0000_1000, 32'd1};
      foreach (limits[i]) begin
         write_threshold(limits[i]);
         if (i == 0) send_command(make_command(CMD_INV, 1, 0, 0, 0, 0));
         if (i == 1) send_command(make_command(CMD_INV, Q_MIN, 0, 0, Q_MIN, 0));
         for (int n = 0; n < 100; n++) begin
            send_command(random_command());
            if (n == 50) drain();
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
